/* hdl/bzc_pkg.sv */
package bzc_pkg;

  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned QUAL_W      = 8;
  localparam int unsigned DIV_CNT_W   = $clog2(TIME_W + 1);
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(TIME_W);

  localparam logic                RST_SCHEDULE_ENABLE = 1'b0;
  localparam logic [TIME_W-1:0]   RST_ANGLE_DIVISOR   = TIME_W'(4);
  localparam logic [SAMPLE_W-1:0] RST_RISE_THRESHOLD  = SAMPLE_W'(25);

  typedef enum logic [1:0] {
    REG_SCHEDULE_ENABLE = 2'd0,
    REG_ANGLE_DIVISOR   = 2'd1,
    REG_RISE_THRESHOLD  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic                schedule_enable;
    logic [TIME_W-1:0]   angle_divisor;
    logic [SAMPLE_W-1:0] rise_threshold;
  } cfg_t;

  typedef struct packed {
    logic                rising_slope;
    logic [SAMPLE_W-1:0] bemf_sample;
    logic [TIME_W-1:0]   now_count;
    logic [TIME_W-1:0]   last_commutation_time;
  } sample_t;

  typedef struct packed {
    logic              crossing_found;
    logic [TIME_W-1:0] measured_period;
    logic              compare_write;
    logic [TIME_W-1:0] next_commutation_time;
    logic [TIME_W-1:0] crossings_seen;
  } result_t;

endpackage

/* hdl/bemf_zero_cross_commutation_timer_unit.sv */
// a sample transaction passes from evaluation to the result load, and through the
// bit-serial divider in between when a crossing schedules the compare
// throughput: one transaction at a time; sample_stall stays high until the result is loaded
// a further sample is taken while an earlier result still waits in the output register
// reset (synchronous) clears qualify counters, crossing count and period, and
// returns registers to schedule_enable 0, angle_divisor 4, rise_threshold 25
module bemf_zero_cross_commutation_timer_unit
  import bzc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_t               sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t              cfg;
  state_t            state;
  state_t            state_next;
  sample_t           item;
  logic              div_start;
  logic              div_done;
  logic [TIME_W-1:0] quot;
  logic [QUAL_W-1:0] fall_cnt;
  logic [QUAL_W-1:0] rise_cnt;
  logic [TIME_W-1:0] cross_cnt;
  logic [TIME_W-1:0] period;
  logic [TIME_W-1:0] period_next;
  logic              found;
  logic              found_next;
  logic              wr_cmp;
  logic [TIME_W-1:0] next_time;
  logic              take;
  logic              load;

  bzc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bzc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (period_next),
    .den   (cfg.angle_divisor),
    .done  (div_done),
    .quot  (quot)
  );

  assign take        = sample_valid && !sample_stall;
  assign period_next = item.now_count - item.last_commutation_time;

  always_comb begin
    if (item.rising_slope) begin
      found_next = (item.bemf_sample > cfg.rise_threshold) && (rise_cnt > QUAL_W'(1));
    end else begin
      found_next = (item.bemf_sample == '0) && (fall_cnt > QUAL_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_stall = 1'b1;
    div_start    = 1'b0;
    load         = 1'b0;
    unique case (state)
      S_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (found_next && cfg.schedule_enable) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!result_valid || !result_stall) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fall_cnt  <= '0;
      rise_cnt  <= '0;
      cross_cnt <= '0;
      period    <= '0;
    end else if (state == S_EVAL) begin
      if (item.rising_slope) begin
        rise_cnt <= found_next ? '0 : rise_cnt + 1'b1;
      end else begin
        fall_cnt <= found_next ? '0 : fall_cnt + 1'b1;
      end
      if (found_next) begin
        cross_cnt <= cross_cnt + 1'b1;
        period    <= period_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      found     <= found_next;
      wr_cmp    <= found_next && cfg.schedule_enable;
      next_time <= '0;
    end else if (state == S_DIV && div_done) begin
      next_time <= item.now_count + quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.crossing_found        <= found;
      result.measured_period       <= period;
      result.compare_write         <= wr_cmp;
      result.next_commutation_time <= next_time;
      result.crossings_seen        <= cross_cnt;
    end
  end

  a_take_eval: assert property (@(posedge clk) disable iff (rst)
    take |=> state == S_EVAL)
    else $error("accepted sample did not enter evaluation");

  a_div_sched: assert property (@(posedge clk) disable iff (rst)
    div_start |-> cfg.schedule_enable && found_next)
    else $error("divider started without a scheduled crossing");

  a_cross_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && found_next) |=> cross_cnt == $past(cross_cnt) + 1'b1)
    else $error("crossing count not advanced");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.compare_write) |-> result.next_commutation_time == '0)
    else $error("compare time set without compare write");

  a_write_found: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.compare_write) |-> result.crossing_found)
    else $error("compare write without crossing");

endmodule

/* hdl/bzc_regs.sv */
module bzc_regs
  import bzc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.schedule_enable <= RST_SCHEDULE_ENABLE;
      cfg.angle_divisor   <= RST_ANGLE_DIVISOR;
      cfg.rise_threshold  <= RST_RISE_THRESHOLD;
    end else if (wr) begin
      unique case (idx)
        REG_SCHEDULE_ENABLE: cfg.schedule_enable <= pwdata[0];
        REG_ANGLE_DIVISOR:   cfg.angle_divisor   <= pwdata[TIME_W-1:0];
        REG_RISE_THRESHOLD:  cfg.rise_threshold  <= pwdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SCHEDULE_ENABLE: prdata = APB_DATA_W'(cfg.schedule_enable);
      REG_ANGLE_DIVISOR:   prdata = APB_DATA_W'(cfg.angle_divisor);
      REG_RISE_THRESHOLD:  prdata = APB_DATA_W'(cfg.rise_threshold);
      default:             prdata = '0;
    endcase
  end

endmodule

/* hdl/bzc_div.sv */
module bzc_div
  import bzc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] num,
  input  logic [TIME_W-1:0] den,
  output logic              done,
  output logic [TIME_W-1:0] quot
);

  logic [TIME_W-1:0]    rem;
  logic [TIME_W-1:0]    quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TIME_W:0]      trial;
  logic [TIME_W+1:0]    diff;
  logic                 ge;

  // restoring step, one quotient bit a cycle
  assign trial = {rem, quo[TIME_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den};
  assign ge    = !diff[TIME_W+1];
  assign quot  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DIV_STEPS;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (cnt != '0) begin
      rem <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      quo <= {quo[TIME_W-2:0], ge};
    end
  end

endmodule
